// ===== rtl/core/rational_arithmetic_unit_assert.svh =====
// Assertion macros for the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RAU_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("rau check failed");
`define RAU_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("rau check failed");
`endif

// ===== rtl/core/rau_pkg.sv =====
package rau_pkg;
  localparam int WORD_BITS = 32;
  localparam int MAG_BITS = 2 * WORD_BITS;
  localparam int IN_BITS = 4 * WORD_BITS;
  localparam int IN_BYTES = (IN_BITS + 7) / 8;
  localparam int OUT_BITS = WORD_BITS + (WORD_BITS - 1) + 2 + 2;
  localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_SUB = 3'd1;
  localparam logic [2:0] KIND_MUL = 3'd2;
  localparam logic [2:0] KIND_DIV = 3'd3;
  localparam logic [2:0] KIND_CMP = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  localparam logic [1:0] CLS_ARITH = 2'd0;
  localparam logic [1:0] CLS_CMP = 2'd1;
  localparam logic [1:0] CLS_FIXED = 2'd2;

  typedef struct packed {
    logic [1:0] cls;
    logic [2:0] kind;
    logic [1:0] status;
    logic san;
    logic sad;
    logic sbn;
    logic sbd;
    logic [WORD_BITS-1:0] man;
    logic [WORD_BITS-1:0] mad;
    logic [WORD_BITS-1:0] mbn;
    logic [WORD_BITS-1:0] mbd;
  } rau_job_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] res_num;
    logic [WORD_BITS-2:0] res_den;
    logic [1:0] status;
    logic is_less;
    logic is_equal;
  } rau_res_t;
endpackage

// ===== rtl/core/rau_front.sv =====
module rau_front import rau_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [2:0] kind,
  input  logic [WORD_BITS-1:0] a_num,
  input  logic [WORD_BITS-1:0] a_den,
  input  logic [WORD_BITS-1:0] b_num,
  input  logic [WORD_BITS-1:0] b_den,
  output logic q_valid,
  input  logic q_ready,
  output rau_job_t q_job
);
  logic [1:0] full;
  rau_job_t slot0;
  rau_job_t slot1;
  rau_job_t job;
  logic push;
  logic pop;

  function automatic logic [WORD_BITS-1:0] mag(input logic [WORD_BITS-1:0] v);
    mag = v[WORD_BITS-1] ? (~v + 1'b1) : v;
  endfunction

  always_comb begin
    job.kind = kind;
    job.san = a_num[WORD_BITS-1];
    job.sad = a_den[WORD_BITS-1];
    job.sbn = b_num[WORD_BITS-1];
    job.sbd = b_den[WORD_BITS-1];
    job.man = mag(a_num);
    job.mad = mag(a_den);
    job.mbn = mag(b_num);
    job.mbd = mag(b_den);
    job.status = ST_OK;
    job.cls = CLS_ARITH;
    if (kind > KIND_CMP) begin
      job.cls = CLS_FIXED;
    end else if (a_den == '0 || b_den == '0) begin
      job.cls = CLS_FIXED;
      job.status = ST_ZERO;
    end else if (kind == KIND_CMP) begin
      job.cls = CLS_CMP;
    end else if (kind == KIND_MUL && (a_num == '0 || b_num == '0)) begin
      job.cls = CLS_FIXED;
    end else if (kind == KIND_DIV && b_num == '0) begin
      job.cls = CLS_FIXED;
      job.status = ST_ZERO;
    end
  end

  assign in_ready = (full != 2'd2);
  assign q_valid = (full != 2'd0);
  assign q_job = slot0;
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 2'd0;
    end else begin
      full <= full + {1'b0, push} - {1'b0, pop};
    end
    if (pop) begin
      slot0 <= slot1;
      if (push && full == 2'd1) slot0 <= job;
      if (push && full == 2'd2) slot1 <= job;
    end else if (push) begin
      if (full == 2'd0) slot0 <= job;
      else slot1 <= job;
    end
  end
endmodule

// ===== rtl/core/rau_back.sv =====
module rau_back import rau_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  rau_job_t q_job,
  output logic out_valid,
  input  logic out_ready,
  output rau_res_t out_res
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL1 = 4'd1;
  localparam logic [3:0] S_MUL2 = 4'd2;
  localparam logic [3:0] S_COMB = 4'd3;
  localparam logic [3:0] S_CHK = 4'd4;
  localparam logic [3:0] S_GCD = 4'd5;
  localparam logic [3:0] S_DIV = 4'd6;
  localparam logic [3:0] S_DONE = 4'd7;
  localparam logic [3:0] S_CMP = 4'd8;
  localparam logic [3:0] S_CDIV = 4'd9;
  localparam logic [3:0] S_CEQ = 4'd10;
  localparam int CNT_BITS = $clog2(MAG_BITS + 1);
  localparam logic [MAG_BITS-1:0] POS_LIM = {{(WORD_BITS + 1){1'b0}}, {(WORD_BITS - 1){1'b1}}};

  logic [3:0] state;
  rau_job_t job;
  logic [MAG_BITS-1:0] p1, p2, p3;
  logic [MAG_BITS-1:0] nmag, dmag;
  logic nneg, neg;
  logic [MAG_BITS-1:0] gx, gy;
  logic [CNT_BITS-1:0] shift;
  logic [MAG_BITS-1:0] dvd, quo, rem, dvs;
  logic [CNT_BITS-1:0] cnt;
  logic phase;
  logic [MAG_BITS-1:0] qn;
  logic lt;
  logic [MAG_BITS-1:0] diff;
  logic [MAG_BITS+9:0] scaled;
  logic [WORD_BITS-1:0] m_a, m_b;
  logic [MAG_BITS-1:0] m_p;
  logic [MAG_BITS:0] rem_sh;
  logic q_bit;
  logic [MAG_BITS-1:0] rem_sub;
  logic [MAG_BITS-1:0] gdiff;
  logic s1, s2, lneg, rneg;

  assign m_p = MAG_BITS'(m_a) * MAG_BITS'(m_b);
  assign rem_sh = {rem, dvd[MAG_BITS-1]};
  assign q_bit = rem_sh >= {1'b0, dvs};
  assign rem_sub = q_bit ? MAG_BITS'(rem_sh - {1'b0, dvs}) : rem_sh[MAG_BITS-1:0];
  assign gdiff = (gx > gy) ? gx - gy : gy - gx;
  assign q_ready = (state == S_IDLE) && !out_valid;
  assign s1 = job.san ^ job.sbd;
  assign s2 = (job.sbn ^ job.sad) ^ (job.kind == KIND_SUB);
  assign lneg = (job.san ^ job.sad) && job.man != '0;
  assign rneg = (job.sbn ^ job.sbd) && job.mbn != '0;

  always_comb begin
    m_a = job.man;
    m_b = job.mbd;
    case (state)
      S_MUL1: begin
        m_a = job.man;
        m_b = (job.kind == KIND_MUL) ? job.mbn : job.mbd;
      end
      S_MUL2: begin
        m_a = job.mbn;
        m_b = job.mad;
      end
      default: begin
        m_a = job.mad;
        m_b = (job.kind == KIND_DIV) ? job.mbn : job.mbd;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            job <= q_job;
            if (q_job.cls == CLS_FIXED) begin
              out_res.res_num <= '0;
              out_res.res_den <= (WORD_BITS-1)'(1);
              out_res.status <= q_job.status;
              out_res.is_less <= 1'b0;
              out_res.is_equal <= 1'b0;
              out_valid <= 1'b1;
            end else begin
              state <= S_MUL1;
            end
          end
        end
        S_MUL1: begin
          p1 <= m_p;
          state <= S_MUL2;
        end
        S_MUL2: begin
          p2 <= m_p;
          state <= S_COMB;
        end
        S_COMB: begin
          p3 <= m_p;
          dmag <= m_p;
          if (job.cls == CLS_CMP) begin
            state <= S_CMP;
          end else begin
            state <= S_CHK;
            if (job.kind == KIND_MUL || job.kind == KIND_DIV) begin
              nmag <= p1;
              nneg <= (job.kind == KIND_MUL) ? (job.san ^ job.sbn) : s1;
            end else if (s1 == s2) begin
              nmag <= p1 + p2;
              nneg <= s1;
            end else if (p1 >= p2) begin
              nmag <= p1 - p2;
              nneg <= s1;
            end else begin
              nmag <= p2 - p1;
              nneg <= s2;
            end
          end
        end
        S_CHK: begin
          neg <= (nneg ^ (job.kind == KIND_DIV ? (job.sad ^ job.sbn) : (job.sad ^ job.sbd)))
                 && nmag != '0;
          if (dmag > POS_LIM || nmag > POS_LIM + MAG_BITS'(
              (nneg ^ (job.kind == KIND_DIV ? (job.sad ^ job.sbn) : (job.sad ^ job.sbd)))
              && nmag != '0)) begin
            out_res.res_num <= '0;
            out_res.res_den <= (WORD_BITS-1)'(1);
            out_res.status <= ST_OVF;
            out_res.is_less <= 1'b0;
            out_res.is_equal <= 1'b0;
            state <= S_DONE;
          end else begin
            gx <= nmag;
            gy <= dmag;
            state <= S_GCD;
          end
        end
        S_GCD: begin
          if (gx == '0) begin
            dvs <= gy << shift;
            dvd <= nmag;
            rem <= '0;
            cnt <= '0;
            phase <= 1'b0;
            state <= S_DIV;
          end else if (gy == '0) begin
            dvs <= gx << shift;
            dvd <= nmag;
            rem <= '0;
            cnt <= '0;
            phase <= 1'b0;
            state <= S_DIV;
          end else if (!gx[0] && !gy[0]) begin
            gx <= gx >> 1;
            gy <= gy >> 1;
            shift <= shift + 1'b1;
          end else if (!gx[0]) begin
            gx <= gx >> 1;
          end else if (!gy[0]) begin
            gy <= gy >> 1;
          end else begin
            gx <= gdiff >> 1;
            gy <= (gx < gy) ? gx : gy;
          end
        end
        S_DIV: begin
          if (cnt == CNT_BITS'(MAG_BITS - 1)) begin
            if (!phase) begin
              phase <= 1'b1;
              dvd <= dmag;
              rem <= '0;
              cnt <= '0;
              qn <= {quo[MAG_BITS-2:0], q_bit};
            end else begin
              out_res.res_num <= neg ? WORD_BITS'(~qn + 1'b1) : qn[WORD_BITS-1:0];
              out_res.res_den <= {quo[WORD_BITS-3:0], q_bit};
              out_res.status <= ST_OK;
              out_res.is_less <= 1'b0;
              out_res.is_equal <= 1'b0;
              state <= S_DONE;
            end
          end else begin
            rem <= rem_sub;
            quo <= {quo[MAG_BITS-2:0], q_bit};
            dvd <= dvd << 1;
            cnt <= cnt + 1'b1;
          end
        end
        S_CMP: begin
          if (lneg != rneg) begin
            lt <= lneg;
            diff <= p1 + p2;
          end else if (p1 >= p2) begin
            lt <= lneg && p1 != p2;
            diff <= p1 - p2;
          end else begin
            lt <= !lneg;
            diff <= p2 - p1;
          end
          state <= S_CDIV;
        end
        S_CDIV: begin
          scaled <= {diff, 10'b0} - {6'b0, diff, 4'b0} - {7'b0, diff, 3'b0};
          state <= S_CEQ;
        end
        S_CEQ: begin
          out_res.res_num <= '0;
          out_res.res_den <= (WORD_BITS-1)'(1);
          out_res.status <= ST_OK;
          out_res.is_less <= lt;
          out_res.is_equal <= scaled < {10'b0, p3};
          state <= S_DONE;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_CHK) shift <= '0;
    end
  end
endmodule

// ===== rtl/core/rational_arithmetic_unit.sv =====
// channel | direction | fields (lsb first)
// s_axis  | in        | tuser: kind; tdata: a_num, a_den, b_num, b_den
// m_axis  | out       | tdata: res_num, res_den, status, is_less, is_equal
// Arithmetic requests run the products, an overflow check, a binary gcd and two serial divisions.
// Overflow ends after the check; compares skip the gcd; errors and trivial cases answer from idle.
// rst is synchronous and clears the queue and the result valid.
// A two-entry queue lets requests land while a result waits on m_axis_tready.
module rational_arithmetic_unit import rau_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [2:0] s_axis_tuser,              // kind
  input  logic [IN_BYTES*8-1:0] s_axis_tdata,   // a_num, a_den, b_num, b_den
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [OUT_BYTES*8-1:0] m_axis_tdata   // res_num, res_den, status, is_less, is_equal
);
  logic q_valid;
  logic q_ready;
  rau_job_t q_job;
  rau_res_t res;

  rau_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .kind(s_axis_tuser),
    .a_num(s_axis_tdata[0 +: WORD_BITS]),
    .a_den(s_axis_tdata[WORD_BITS +: WORD_BITS]),
    .b_num(s_axis_tdata[2*WORD_BITS +: WORD_BITS]),
    .b_den(s_axis_tdata[3*WORD_BITS +: WORD_BITS]),
    .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job)
  );

  rau_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
  );

  assign m_axis_tdata = {{(OUT_BYTES*8 - OUT_BITS){1'b0}}, res.is_equal, res.is_less,
                         res.status, res.res_den, res.res_num};

`include "rational_arithmetic_unit_assert.svh"
  `RAU_ASSERT_IMPL(a_status_range, m_axis_tvalid,
                   res.status == ST_OK || res.status == ST_ZERO || res.status == ST_OVF)
  `RAU_ASSERT_IMPL(a_err_clean, m_axis_tvalid && res.status != ST_OK,
                   res.res_num == '0 && !res.is_less && !res.is_equal)
  `RAU_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(res))
endmodule
